FILE: rtl/gclrw_pkg.sv
package gclrw_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BUDGET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_GROUPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_END_INDEX = 2'd2;

    localparam logic [19:0] WORD_BUDGET_RESET = 20'hFFFFF;
    localparam logic        ALIGN_RESET       = 1'b1;
    localparam logic [9:0]  BLOCK_END_RESET   = 10'd573;
    localparam logic [19:0] COUNT_MAX         = 20'hFFFFF;

    typedef enum logic [1:0] {
        PH_PARAM,
        PH_HEADER,
        PH_EXTRA,
        PH_PAD
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] idx;
        logic [31:0] value;
        logic [3:0]  be;
        logic        ended;
    } op_t;

    typedef struct packed {
        logic        write_valid;
        logic [9:0]  write_index;
        logic [31:0] write_value;
        logic [31:0] read_data;
        logic        block_ended;
    } result_t;

    function automatic logic [31:0] lane_mask(input logic [3:0] be);
        logic [31:0] m;
        for (int i = 0; i < 4; i++)
        begin
            m[8*i +: 8] = {8{be[i]}};
        end
        return m;
    endfunction

endpackage

FILE: rtl/gclrw_ram.sv
module gclrw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/gclrw_fifo.sv
module gclrw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign count    = count_reg;
    assign pop_data = mem_reg[head_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/gclrw_front.sv
module gclrw_front #(
    parameter int REG_COUNT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gclrw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gclrw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    input  logic                             kind,
    input  logic [31:0]                      stream_word,
    input  logic [9:0]                       read_index,
    input  logic                             busy,
    output logic                             full,
    output logic                             op_push,
    output gclrw_pkg::op_t                   op
);

    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);

    gclrw_pkg::phase_t phase_reg, phase_next;
    logic [31:0] held_reg, held_next;
    logic [15:0] index_reg, index_next;
    logic [3:0]  be_reg, be_next;
    logic [10:0] extra_reg, extra_next;
    logic        cons_reg, cons_next;
    logic        parity_reg, parity_next;
    logic [19:0] words_reg, words_next;
    logic        ended_reg, ended_next;
    logic [19:0] budget_reg;
    logic        align_reg;
    logic [9:0]  block_end_reg;

    logic        accept;
    logic [19:0] words_inc;
    logic [15:0] hdr_index;
    logic [10:0] hdr_extra;
    logic [15:0] ext_index;
    logic        hdr_in_range, ext_in_range, read_in_range;

    assign full          = busy;
    assign accept        = push && !busy;
    assign op_push       = accept;
    assign words_inc     = (words_reg == gclrw_pkg::COUNT_MAX) ? words_reg : words_reg + 20'd1;
    assign hdr_index     = stream_word[15:0];
    assign hdr_extra     = stream_word[30:20];
    assign ext_index     = cons_reg ? index_reg + 16'd1 : index_reg;
    assign hdr_in_range  = {1'b0, hdr_index} < REG_LIMIT;
    assign ext_in_range  = {1'b0, ext_index} < REG_LIMIT;
    assign read_in_range = {7'd0, read_index} < REG_LIMIT;

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        index_next  = index_reg;
        be_next     = be_reg;
        extra_next  = extra_reg;
        cons_next   = cons_reg;
        parity_next = parity_reg;
        words_next  = words_reg;
        ended_next  = ended_reg;
        op          = '0;
        op.kind     = gclrw_pkg::OP_NONE;
        op.ended    = ended_reg;
        if (accept)
        begin
            if (kind)
            begin
                if (read_in_range)
                begin
                    op.kind = gclrw_pkg::OP_READ;
                    op.idx  = {6'd0, read_index};
                end
            end
            else if (!ended_reg)
            begin
                case (phase_reg)
                    gclrw_pkg::PH_PARAM:
                    begin
                        if (words_reg < budget_reg)
                        begin
                            held_next  = stream_word;
                            words_next = words_inc;
                            phase_next = gclrw_pkg::PH_HEADER;
                        end
                    end
                    gclrw_pkg::PH_HEADER:
                    begin
                        words_next  = words_inc;
                        index_next  = hdr_index;
                        be_next     = stream_word[19:16];
                        extra_next  = hdr_extra;
                        cons_next   = stream_word[31];
                        parity_next = hdr_extra[0];
                        if (hdr_in_range)
                        begin
                            op.kind  = gclrw_pkg::OP_WRITE;
                            op.idx   = hdr_index;
                            op.value = held_reg;
                            op.be    = stream_word[19:16];
                        end
                        if (hdr_index == {6'd0, block_end_reg})
                        begin
                            // stop the list; its extra words are never consumed
                            ended_next = 1'b1;
                            op.ended   = 1'b1;
                            phase_next = gclrw_pkg::PH_PARAM;
                        end
                        else if (hdr_extra != 11'd0)
                        begin
                            phase_next = gclrw_pkg::PH_EXTRA;
                        end
                        else
                        begin
                            phase_next = (align_reg && hdr_extra[0]) ?
                                         gclrw_pkg::PH_PAD : gclrw_pkg::PH_PARAM;
                        end
                    end
                    gclrw_pkg::PH_EXTRA:
                    begin
                        words_next = words_inc;
                        index_next = ext_index;
                        extra_next = extra_reg - 11'd1;
                        if (ext_in_range)
                        begin
                            op.kind  = gclrw_pkg::OP_WRITE;
                            op.idx   = ext_index;
                            op.value = stream_word;
                            op.be    = be_reg;
                        end
                        if (extra_reg == 11'd1)
                        begin
                            phase_next = (align_reg && parity_reg) ?
                                         gclrw_pkg::PH_PAD : gclrw_pkg::PH_PARAM;
                        end
                    end
                    gclrw_pkg::PH_PAD:
                    begin
                        // drop the padding word, uncounted
                        phase_next = gclrw_pkg::PH_PARAM;
                    end
                    default:
                    begin
                        phase_next = gclrw_pkg::PH_PARAM;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gclrw_pkg::PH_PARAM;
            held_reg   <= '0;
            index_reg  <= '0;
            be_reg     <= '0;
            extra_reg  <= '0;
            cons_reg   <= 1'b0;
            parity_reg <= 1'b0;
            words_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            index_reg  <= index_next;
            be_reg     <= be_next;
            extra_reg  <= extra_next;
            cons_reg   <= cons_next;
            parity_reg <= parity_next;
            words_reg  <= words_next;
            ended_reg  <= ended_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= gclrw_pkg::WORD_BUDGET_RESET;
            align_reg     <= gclrw_pkg::ALIGN_RESET;
            block_end_reg <= gclrw_pkg::BLOCK_END_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gclrw_pkg::CFG_WORD_BUDGET:     budget_reg    <= cfg_data;
                gclrw_pkg::CFG_ALIGN_GROUPS:    align_reg     <= cfg_data[0];
                gclrw_pkg::CFG_BLOCK_END_INDEX: block_end_reg <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/gclrw_back.sv
module gclrw_back #(
    parameter int REG_COUNT = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    input  gclrw_pkg::op_t               op,
    output logic                         op_pop,
    input  logic [gclrw_pkg::OUT_CW-1:0] out_count,
    output logic                         res_push,
    output gclrw_pkg::result_t           res,
    output logic                         clearing
);

    localparam int AW = $clog2(REG_COUNT);
    localparam int IW = gclrw_pkg::OUT_CW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(REG_COUNT - 1);

    logic              clear_reg;
    logic [AW-1:0]     clear_addr_reg;
    logic              s1_valid_reg;
    gclrw_pkg::op_t    s1_op_reg;
    logic              s1_fwd_reg;
    logic [31:0]       s1_fwd_val_reg;

    logic [31:0]       rdata, old_value, merged, mask;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic              s1_writes, fwd_hit;
    logic [IW-1:0]     in_flight;

    assign clearing  = clear_reg;
    // reserve room in the result queue for the transaction already in flight
    assign in_flight = {1'b0, out_count} + IW'(s1_valid_reg);
    assign op_pop    = op_valid && !clear_reg && (in_flight < IW'(gclrw_pkg::OUT_DEPTH));

    assign mask      = gclrw_pkg::lane_mask(s1_op_reg.be);
    assign old_value = s1_fwd_reg ? s1_fwd_val_reg : rdata;
    assign merged    = (old_value & ~mask) | (s1_op_reg.value & mask);
    assign s1_writes = s1_valid_reg && (s1_op_reg.kind == gclrw_pkg::OP_WRITE);
    // the word now being written is missed by the read issued at the same edge
    assign fwd_hit   = s1_writes && (s1_op_reg.idx[AW-1:0] == op.idx[AW-1:0]);

    assign ram_we    = clear_reg || s1_writes;
    assign ram_waddr = clear_reg ? clear_addr_reg : s1_op_reg.idx[AW-1:0];
    assign ram_wdata = clear_reg ? 32'd0 : merged;
    assign res_push  = s1_valid_reg;

    always_comb
    begin
        res             = '0;
        res.block_ended = s1_op_reg.ended;
        case (s1_op_reg.kind)
            gclrw_pkg::OP_WRITE:
            begin
                res.write_valid = 1'b1;
                res.write_index = s1_op_reg.idx[9:0];
                res.write_value = merged;
            end
            gclrw_pkg::OP_READ:
            begin
                res.read_data = old_value;
            end
            default:
            begin
            end
        endcase
    end

    gclrw_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (op.idx[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_fwd_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= op_pop;
            s1_fwd_reg   <= fwd_hit;
            if (clear_reg)
            begin
                if (clear_addr_reg == LAST_ADDR)
                begin
                    clear_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fwd_val_reg <= merged;
        if (op_pop)
        begin
            s1_op_reg <= op;
        end
    end

endmodule

FILE: rtl/gpu_command_list_register_writer.sv
// An item's result reaches the result ports through the mid queue, the s1 stage
// register and the result queue. Throughput: one item per cycle while full is low,
// via a read-modify-write of the register file RAM (one write port, one registered
// read port, one-deep forwarding). Reset: asynchronous, active low; then full stays
// high while a clearing pass zeroes the register file one entry a cycle.
module gpu_command_list_register_writer #(
    parameter int REG_COUNT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gclrw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gclrw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [31:0]                      stream_word,
    input  logic [9:0]                       read_index,
    output logic                             empty,
    input  logic                             pop,
    output logic                             write_valid,
    output logic [9:0]                       write_index,
    output logic [31:0]                      write_value,
    output logic [31:0]                      read_data,
    output logic                             block_ended
);

    gclrw_pkg::op_t     front_op, mid_op;
    gclrw_pkg::result_t back_res, head_res;
    logic               front_push, mid_full, mid_empty, mid_pop;
    logic               clearing, res_push;
    logic [gclrw_pkg::OUT_CW-1:0] out_count;

    gclrw_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .kind        (kind),
        .stream_word (stream_word),
        .read_index  (read_index),
        .busy        (mid_full || clearing),
        .full        (full),
        .op_push     (front_push),
        .op          (front_op)
    );

    gclrw_fifo #(
        .WIDTH ($bits(gclrw_pkg::op_t)),
        .DEPTH (gclrw_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_op),
        .pop       (mid_pop),
        .pop_data  (mid_op),
        .empty     (mid_empty),
        .full      (mid_full),
        .count     ()
    );

    gclrw_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (!mid_empty),
        .op        (mid_op),
        .op_pop    (mid_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (back_res),
        .clearing  (clearing)
    );

    gclrw_fifo #(
        .WIDTH ($bits(gclrw_pkg::result_t)),
        .DEPTH (gclrw_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .pop       (pop),
        .pop_data  (head_res),
        .empty     (empty),
        .full      (),
        .count     (out_count)
    );

    assign write_valid = head_res.write_valid;
    assign write_index = head_res.write_index;
    assign write_value = head_res.write_value;
    assign read_data   = head_res.read_data;
    assign block_ended = head_res.block_ended;

endmodule

FILE: rtl/gclrw_checker.sv
module gclrw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        write_valid,
    input logic [31:0] read_data,
    input logic        block_ended
);

    logic [4:0] outstanding_reg, outstanding_next;
    logic       in_txn, out_txn;

    assign in_txn  = push && !full;
    assign out_txn = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_txn && !out_txn)
        begin
            outstanding_next = outstanding_reg + 5'd1;
        end
        else if (out_txn && !in_txn)
        begin
            outstanding_next = outstanding_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // no result without an accepted transaction behind it
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outstanding_reg != 5'd0)
        else $error("result shown with no transaction outstanding");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before it was taken");

    // the end-of-list flag never drops once reported
    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_txn && block_ended |=> empty || block_ended)
        else $error("block_ended fell after the list had ended");

    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && write_valid |-> read_data == 32'd0)
        else $error("write result carries read data");

endmodule

bind gpu_command_list_register_writer gclrw_checker u_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FILE_SIZE      = 1024;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        is_read;
        logic [31:0] word;
        logic [9:0]  ridx;
    } stream_item_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_write   = 1'b0;
    logic [gclrw_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [gclrw_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                             push        = 1'b0;
    logic                             kind        = 1'b0;
    logic [31:0]                      stream_word = '0;
    logic [9:0]                       read_index  = '0;
    logic                             pop         = 1'b0;
    logic                             full;
    logic                             empty;
    logic                             write_valid;
    logic [9:0]                       write_index;
    logic [31:0]                      write_value;
    logic [31:0]                      read_data;
    logic                             block_ended;

    // configuration as the block currently holds it
    logic [19:0] cfg_budget  = gclrw_pkg::WORD_BUDGET_RESET;
    logic        cfg_align   = gclrw_pkg::ALIGN_RESET;
    logic [9:0]  cfg_end_idx = gclrw_pkg::BLOCK_END_RESET;

    // parser state mirrored on the testbench side
    gclrw_pkg::phase_t parse_state = gclrw_pkg::PH_PARAM;
    logic [31:0] held_word   = '0;
    logic [15:0] cur_reg     = '0;
    logic [3:0]  lane_en     = '0;
    logic [10:0] extras_left = '0;
    logic        step_up     = 1'b0;
    logic        odd_group   = 1'b0;
    logic [19:0] words_taken = '0;
    logic        list_done   = 1'b0;
    logic [31:0] shadow_regs [0:FILE_SIZE-1];

    stream_item_t       stream_backlog[$];
    gclrw_pkg::result_t parser_outcomes[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int reads_taken   = 0;
    int results_seen  = 0;
    int writes_seen   = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int stall_pct     = 0;
    int window_left   = 0;
    int burst_left    = 0;
    int gap_left      = 0;

    stream_item_t       item_now;
    gclrw_pkg::result_t want_now;
    logic               moved;

    gpu_command_list_register_writer #(
        .REG_COUNT(FILE_SIZE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .stream_word(stream_word),
        .read_index (read_index),
        .empty      (empty),
        .pop        (pop),
        .write_valid(write_valid),
        .write_index(write_index),
        .write_value(write_value),
        .read_data  (read_data),
        .block_ended(block_ended)
    );

    always #1 clk = ~clk;

    function automatic void tick_words();
        if (words_taken != gclrw_pkg::COUNT_MAX)
            words_taken++;
    endfunction

    function automatic void close_group();
        parse_state = (cfg_align && odd_group) ? gclrw_pkg::PH_PAD : gclrw_pkg::PH_PARAM;
    endfunction

    function automatic gclrw_pkg::result_t merge_into_file(input logic [15:0] idx,
                                                           input logic [31:0] value);
        gclrw_pkg::result_t r;
        logic [31:0]        lanes;
        r = '0;
        if (idx < FILE_SIZE)
        begin
            lanes = {{8{lane_en[3]}}, {8{lane_en[2]}}, {8{lane_en[1]}}, {8{lane_en[0]}}};
            shadow_regs[idx[9:0]] = (shadow_regs[idx[9:0]] & ~lanes) | (value & lanes);
            r.write_valid = 1'b1;
            r.write_index = idx[9:0];
            r.write_value = shadow_regs[idx[9:0]];
        end
        return r;
    endfunction

    function automatic gclrw_pkg::result_t advance_parser(input stream_item_t it);
        gclrw_pkg::result_t r;
        r = '0;
        if (it.is_read)
        begin
            r.read_data   = shadow_regs[it.ridx];
            r.block_ended = list_done;
            return r;
        end
        if (!list_done)
        begin
            case (parse_state)
                gclrw_pkg::PH_PARAM:
                begin
                    // over budget: drop the word and stay between groups
                    if (words_taken < cfg_budget)
                    begin
                        held_word   = it.word;
                        tick_words();
                        parse_state = gclrw_pkg::PH_HEADER;
                    end
                end
                gclrw_pkg::PH_HEADER:
                begin
                    tick_words();
                    cur_reg     = it.word[15:0];
                    lane_en     = it.word[19:16];
                    extras_left = it.word[30:20];
                    step_up     = it.word[31];
                    odd_group   = it.word[20];
                    r = merge_into_file(cur_reg, held_word);
                    if (cur_reg == {6'd0, cfg_end_idx})
                    begin
                        list_done   = 1'b1;
                        parse_state = gclrw_pkg::PH_PARAM;
                    end
                    else if (extras_left != 0)
                        parse_state = gclrw_pkg::PH_EXTRA;
                    else
                        close_group();
                end
                gclrw_pkg::PH_EXTRA:
                begin
                    tick_words();
                    if (step_up)
                        cur_reg = cur_reg + 16'd1;
                    r = merge_into_file(cur_reg, it.word);
                    extras_left = extras_left - 11'd1;
                    if (extras_left == 0)
                        close_group();
                end
                default:
                    parse_state = gclrw_pkg::PH_PARAM;
            endcase
        end
        r.block_ended = list_done;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] make_header(input logic [15:0] idx, input logic [3:0] be,
                                                input logic [10:0] n_extra, input logic up);
        return {up, n_extra, be, idx};
    endfunction

    function automatic logic [9:0] pick_read_index();
        if ($urandom_range(0, 3) == 0)
            return 10'($urandom_range(0, FILE_SIZE - 1));
        return $urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom_range(1008, 1023));
    endfunction

    // never lands on the block-end register, so the list keeps running
    function automatic logic [15:0] pick_index();
        logic [15:0] i;
        i = {6'd0, cfg_end_idx};
        while (i == {6'd0, cfg_end_idx})
        begin
            case ($urandom_range(0, 9))
                0:       i = 16'($urandom_range(FILE_SIZE, 65535));
                1:       i = 16'hFFFF;
                2, 3:    i = 16'($urandom_range(0, FILE_SIZE - 1));
                default: i = 16'(pick_read_index());
            endcase
        end
        return i;
    endfunction

    // any word may be parsed as a header in a broken stream: keep its extra count
    // short and its index off the block-end register
    function automatic logic [31:0] safe_word(input logic [31:0] w);
        logic [31:0] s;
        s = w;
        s[30:23] = '0;
        if (s[15:0] == {6'd0, cfg_end_idx})
            s[10] = 1'b1;
        return s;
    endfunction

    function automatic void add_word(input logic [31:0] w);
        stream_item_t it;
        it.is_read = 1'b0;
        it.word    = w;
        it.ridx    = 10'($urandom_range(0, FILE_SIZE - 1));
        stream_backlog.push_back(it);
        items_queued++;
    endfunction

    function automatic void add_read(input logic [9:0] r);
        stream_item_t it;
        it.is_read = 1'b1;
        it.word    = $urandom;
        it.ridx    = r;
        stream_backlog.push_back(it);
        items_queued++;
    endfunction

    function automatic void add_group(input logic noisy);
        logic [31:0] words[$];
        int          n_extra;
        n_extra = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        words.push_back(noisy ? safe_word($urandom) : $urandom);
        words.push_back(make_header(pick_index(), 4'($urandom_range(0, 15)), 11'(n_extra),
                                    1'($urandom_range(0, 1))));
        repeat (n_extra)
            words.push_back(noisy ? safe_word($urandom) : $urandom);
        if (cfg_align && n_extra[0])
            words.push_back(noisy ? safe_word($urandom) : $urandom);
        // break the group by dropping one of its words
        if (noisy && $urandom_range(0, 1))
            words.delete($urandom_range(0, words.size() - 1));
        foreach (words[i])
        begin
            if ($urandom_range(0, 6) == 0)
                add_read(pick_read_index());
            add_word(words[i]);
        end
    endfunction

    task automatic wait_until_settled();
        while (stream_backlog.size() != 0 || parser_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_register(input logic [gclrw_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [gclrw_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            gclrw_pkg::CFG_WORD_BUDGET:     cfg_budget  = data;
            gclrw_pkg::CFG_ALIGN_GROUPS:    cfg_align   = data[0];
            gclrw_pkg::CFG_BLOCK_END_INDEX: cfg_end_idx = data[9:0];
            default: ;
        endcase
    endtask

    task automatic fill_random(input int count, input logic noisy);
        int start;
        start = items_queued;
        while (items_queued - start < count)
        begin
            if (noisy && $urandom_range(0, 2) == 0)
                add_word(safe_word($urandom));
            else
                add_group(noisy);
            // now and then hold the stream until every transaction has drained
            if ($urandom_range(0, 29) == 0)
                wait_until_settled();
        end
    endtask

    // finish whatever group a broken stream left open
    task automatic realign_parser();
        while (parse_state != gclrw_pkg::PH_PARAM && !list_done)
        begin
            case (parse_state)
                gclrw_pkg::PH_HEADER: add_word(make_header(pick_index(), 4'hF, 11'd0, 1'b0));
                gclrw_pkg::PH_EXTRA:  repeat (extras_left) add_word($urandom);
                default:              add_word($urandom);
            endcase
            wait_until_settled();
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left--;
            push <= 1'b0;
        end
        else if (stream_backlog.size() > 0)
        begin
            push        <= 1'b1;
            kind        <= stream_backlog[0].is_read;
            stream_word <= stream_backlog[0].word;
            read_index  <= stream_backlog[0].ridx;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
            push <= 1'b0;
    end

    // receiver: stall rate changes per window, plus requested long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (window_left == 0)
            begin
                window_left = $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 60;
                endcase
            end
            else
                window_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (parser_outcomes.size() == 0)
                begin
                    $error("result transaction arrived with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want_now = parser_outcomes.pop_front();
                    check_field("write_valid", want_now.write_valid, write_valid);
                    check_field("write_index", want_now.write_index, write_index);
                    check_field("write_value", want_now.write_value, write_value);
                    check_field("read_data", want_now.read_data, read_data);
                    check_field("block_ended", want_now.block_ended, block_ended);
                    results_seen++;
                    if (want_now.write_valid)
                        writes_seen++;
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                item_now = stream_backlog.pop_front();
                parser_outcomes.push_back(advance_parser(item_now));
                items_taken++;
                if (item_now.is_read)
                    reads_taken++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("[gpu_command_list_register_writer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: alignment on, block end at its reset index
        add_read(10'd0);
        add_read(10'd1023);
        add_word(32'hFFFFFFFF);
        add_word(make_header(16'd5, 4'hF, 11'd0, 1'b0));
        add_word(32'h00000000);
        add_word(make_header(16'd5, 4'b0101, 11'd1, 1'b0));
        add_word(32'h12345678);
        add_word(32'hFFFFFFFF);
        // consecutive from the top of the index range wraps to zero
        add_word(32'hA5A5A5A5);
        add_word(make_header(16'hFFFF, 4'hF, 11'd3, 1'b1));
        add_word(32'h11111111);
        add_word(32'h22222222);
        add_word(32'h00000000);
        add_word(32'h00000000);
        add_word(32'hDEADBEEF);
        add_word(make_header(16'd1024, 4'hF, 11'd0, 1'b0));
        add_word(32'hCAFEF00D);
        add_word(make_header(16'd7, 4'h0, 11'd0, 1'b0));
        add_word(32'h0F0F0F0F);
        add_word(make_header(16'd1023, 4'b1010, 11'd0, 1'b0));
        add_read(10'd5);
        add_read(10'd0);
        add_read(10'd2);
        add_read(10'd1023);
        add_read(10'd7);
        wait_until_settled();

        set_register(gclrw_pkg::CFG_WORD_BUDGET, gclrw_pkg::WORD_BUDGET_RESET);
        set_register(gclrw_pkg::CFG_ALIGN_GROUPS, 20'd0);
        set_register(gclrw_pkg::CFG_BLOCK_END_INDEX, 20'd0);
        fill_random(120, 1'b0);
        wait_until_settled();

        set_register(gclrw_pkg::CFG_ALIGN_GROUPS, 20'd1);
        set_register(gclrw_pkg::CFG_BLOCK_END_INDEX, 20'd1023);
        holds_asked++;
        fill_random(120, 1'b0);
        wait_until_settled();

        // budget exhausted, then a budget that runs out a few groups in
        set_register(gclrw_pkg::CFG_WORD_BUDGET, 20'd0);
        fill_random(12, 1'b0);
        wait_until_settled();
        set_register(gclrw_pkg::CFG_WORD_BUDGET, words_taken + 20'd7);
        fill_random(30, 1'b0);
        wait_until_settled();
        set_register(gclrw_pkg::CFG_WORD_BUDGET, gclrw_pkg::WORD_BUDGET_RESET);

        set_register(gclrw_pkg::CFG_ALIGN_GROUPS, 20'($urandom_range(0, 1)));
        set_register(gclrw_pkg::CFG_BLOCK_END_INDEX, 20'($urandom_range(1, 1022)));
        fill_random(80, 1'b1);
        wait_until_settled();
        realign_parser();
        fill_random(110, 1'b0);
        wait_until_settled();

        // end the list; stream words after it are ignored, reads are still answered
        set_register(gclrw_pkg::CFG_BLOCK_END_INDEX, 20'($urandom_range(0, FILE_SIZE - 1)));
        fill_random(10, 1'b0);
        add_word($urandom);
        add_word(make_header({6'd0, cfg_end_idx}, 4'($urandom_range(0, 15)), 11'd3,
                             1'($urandom_range(0, 1))));
        repeat (3) add_word($urandom);
        add_read(cfg_end_idx);
        fill_random(16, 1'b0);
        add_read(cfg_end_idx);
        wait_until_settled();
        repeat (8) @(posedge clk);

        $display("covered %0d items (%0d reads), %0d results checked, %0d register writes",
                 items_taken, reads_taken, results_seen, writes_seen);
        $display("budget 0 to max, alignment on and off, end index 0 and 1023, list end %s",
                 list_done ? "reached" : "missed");
        if (fail_count == 0)
            $display("[gpu_command_list_register_writer] OK");
        else
            $display("[gpu_command_list_register_writer] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gclrw_pkg.sv
rtl/gclrw_ram.sv
rtl/gclrw_fifo.sv
rtl/gclrw_front.sv
rtl/gclrw_back.sv
rtl/gpu_command_list_register_writer.sv
rtl/gclrw_checker.sv
tb/tb.sv
